/* design/rc4_pkg.sv */
// ----------------------------------------------------------------------------
// rc4_pkg: shared types and constants for the rc4 stream cipher
// Item kinds, table sizes and the permutation store request bundle.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int unsigned TABLE_SIZE = 256;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 9;

  localparam logic [LEN_W-1:0]  KEY_LEN_RESET = 9'd16;
  localparam logic [BYTE_W-1:0] LAST_INDEX    = 8'hFF;

  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_SCHED = 2'd1,
    KIND_DATA  = 2'd2
  } kind_e;

  // one read and one write per cycle, plus a clear back to identity
  typedef struct packed {
    logic              clear;
    logic              we;
    logic [BYTE_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic [BYTE_W-1:0] raddr;
  } perm_req_t;

endpackage

/* design/rc4_key_ram.sv */
// ----------------------------------------------------------------------------
// rc4_key_ram: key byte store
// 256 x 8 memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rc4_key_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [rc4_pkg::BYTE_W-1:0] waddr_i,
  input  logic [rc4_pkg::BYTE_W-1:0] wdata_i,
  input  logic [rc4_pkg::BYTE_W-1:0] raddr_i,
  output logic [rc4_pkg::BYTE_W-1:0] rdata_o
);

  logic [rc4_pkg::BYTE_W-1:0] mem [rc4_pkg::TABLE_SIZE];
  logic [rc4_pkg::BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/rc4_perm_ram.sv */
// ----------------------------------------------------------------------------
// rc4_perm_ram: permutation table store
// 256 x 8 memory with per-entry valid bits; an entry not written since the
// last clear reads as its own index. Reads are write-first.
// ----------------------------------------------------------------------------
module rc4_perm_ram (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rc4_pkg::perm_req_t         req_i,
  output logic [rc4_pkg::BYTE_W-1:0] rdata_o
);

  logic [rc4_pkg::BYTE_W-1:0]     mem [rc4_pkg::TABLE_SIZE];
  logic [rc4_pkg::TABLE_SIZE-1:0] valid_q;
  logic [rc4_pkg::BYTE_W-1:0]     mem_q;
  logic [rc4_pkg::BYTE_W-1:0]     wdata_q;
  logic [rc4_pkg::BYTE_W-1:0]     raddr_q;
  logic                           hit_q;
  logic                           rvalid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    mem_q   <= mem[req_i.raddr];
    wdata_q <= req_i.wdata;
    raddr_q <= req_i.raddr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      hit_q    <= 1'b0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.clear) begin
        valid_q <= '0;
      end else if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      hit_q    <= req_i.we && (req_i.waddr == req_i.raddr);
      rvalid_q <= valid_q[req_i.raddr];
    end
  end

  // same-cycle write bypass, then identity for untouched entries
  assign rdata_o = hit_q ? wdata_q : (rvalid_q ? mem_q : raddr_q);

  a_write_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.we && (req_i.waddr == req_i.raddr)) |=> (rdata_o == $past(req_i.wdata)))
    else $error("perm store read missed same-cycle write");

  a_clear_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.clear |=> (valid_q == '0))
    else $error("perm store clear left valid entries");

  a_unwritten_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!req_i.we && !valid_q[req_i.raddr]) |=> (rdata_o == $past(req_i.raddr)))
    else $error("untouched perm entry did not read as identity");

endmodule

/* design/rc4_stream_cipher.sv */
// ----------------------------------------------------------------------------
// rc4_stream_cipher: rc4 keystream generator and key scheduler
// Data byte: states D1, D2 and D3 follow the transfer, and the result is registered
// in D3 once the output register is free; a new item is taken in the cycle the
// result is registered. The i read, j read and output read share the single perm
// store port. Key byte: written on transfer. Schedule: K0, K1, K2 per table entry, then KW.
// Reset: identity table, indices zero, key length 16, key store undefined.
// ----------------------------------------------------------------------------
module rc4_stream_cipher (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [rc4_pkg::LEN_W-1:0] cfg_wdata_i,   // key_length
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [15:0]               s_axis_tdata,  // key_index[7:0], byte_value[15:8]
  input  logic [1:0]                s_axis_tuser,  // kind[1:0]
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [15:0]               m_axis_tdata   // out_byte[7:0], stream_byte[15:8]
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_D1   = 3'd1;
  localparam logic [2:0] ST_D2   = 3'd2;
  localparam logic [2:0] ST_D3   = 3'd3;
  localparam logic [2:0] ST_K0   = 3'd4;
  localparam logic [2:0] ST_K1   = 3'd5;
  localparam logic [2:0] ST_K2   = 3'd6;
  localparam logic [2:0] ST_KW   = 3'd7;

  localparam int unsigned BW = rc4_pkg::BYTE_W;
  localparam int unsigned LW = rc4_pkg::LEN_W;

  logic [2:0]    state_q, state_d;
  logic [BW-1:0] i_q, i_d, j_q, j_d;
  logic [BW-1:0] si_q, si_d, t_q, t_d;
  logic [BW-1:0] data_q, data_d;
  logic [BW-1:0] n_q, n_d, kpos_q, kpos_d;
  logic [BW-1:0] acc_q, acc_d, sn_q, sn_d;
  logic          wb_q, wb_d;
  logic [LW-1:0] key_len_q;
  logic [LW-1:0] len_eff;
  logic          out_valid_q, out_valid_d;
  logic [15:0]   out_data_q, out_data_d;

  logic          accept;
  logic          out_free;
  logic [BW-1:0] ks;
  logic [BW-1:0] perm_rdata;
  logic [BW-1:0] key_rdata;
  logic          key_we;
  rc4_pkg::perm_req_t perm_req;
  rc4_pkg::kind_e     kind;

  assign kind     = rc4_pkg::kind_e'(s_axis_tuser);
  assign out_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) || ((state_q == ST_D3) && out_free);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign key_we   = accept && (kind == rc4_pkg::KIND_KEY);

  // length zero or above the table size runs over the whole table
  assign len_eff = ((key_len_q == '0) || (key_len_q > LW'(rc4_pkg::TABLE_SIZE))) ?
                   LW'(rc4_pkg::TABLE_SIZE) : key_len_q;

  // s[j] is still being written back when the output entry is read
  assign ks = (t_q == j_q) ? si_q : perm_rdata;

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    si_d        = si_q;
    t_d         = t_q;
    data_d      = data_q;
    n_d         = n_q;
    kpos_d      = kpos_q;
    acc_d       = acc_q;
    sn_d        = sn_q;
    wb_d        = wb_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    perm_req       = '0;
    perm_req.raddr = t_q;

    unique case (state_q)
      ST_IDLE: begin
      end
      ST_D1: begin
        si_d           = perm_rdata;
        j_d            = j_q + perm_rdata;
        perm_req.raddr = j_q + perm_rdata;
        state_d        = ST_D2;
      end
      ST_D2: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = i_q;
        perm_req.wdata = perm_rdata;
        t_d            = si_q + perm_rdata;
        perm_req.raddr = si_q + perm_rdata;
        state_d        = ST_D3;
      end
      ST_D3: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = j_q;
        perm_req.wdata = si_q;
        perm_req.raddr = t_q;
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {ks, data_q ^ ks};
          state_d     = ST_IDLE;
        end
      end
      ST_K0: begin
        perm_req.raddr = n_q;
        if (wb_q) begin
          perm_req.we    = 1'b1;
          perm_req.waddr = acc_q;
          perm_req.wdata = sn_q;
        end
        state_d = ST_K1;
      end
      ST_K1: begin
        sn_d           = perm_rdata;
        acc_d          = acc_q + perm_rdata + key_rdata;
        perm_req.raddr = acc_q + perm_rdata + key_rdata;
        state_d        = ST_K2;
      end
      ST_K2: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = n_q;
        perm_req.wdata = perm_rdata;
        n_d            = n_q + 8'd1;
        wb_d           = 1'b1;
        if (({1'b0, kpos_q} + 9'd1) >= len_eff) begin
          kpos_d = '0;
        end else begin
          kpos_d = kpos_q + 8'd1;
        end
        state_d = (n_q == rc4_pkg::LAST_INDEX) ? ST_KW : ST_K0;
      end
      ST_KW: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = acc_q;
        perm_req.wdata = sn_q;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (accept) begin
      case (kind)
        rc4_pkg::KIND_SCHED: begin
          perm_req.clear = 1'b1;
          i_d     = '0;
          j_d     = '0;
          n_d     = '0;
          kpos_d  = '0;
          acc_d   = '0;
          wb_d    = 1'b0;
          state_d = ST_K0;
        end
        rc4_pkg::KIND_DATA: begin
          i_d            = i_q + 8'd1;
          perm_req.raddr = i_q + 8'd1;
          data_d         = s_axis_tdata[15:8];
          state_d        = ST_D1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      si_q        <= '0;
      t_q         <= '0;
      n_q         <= '0;
      kpos_q      <= '0;
      acc_q       <= '0;
      sn_q        <= '0;
      wb_q        <= 1'b0;
      key_len_q   <= rc4_pkg::KEY_LEN_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      si_q        <= si_d;
      t_q         <= t_d;
      n_q         <= n_d;
      kpos_q      <= kpos_d;
      acc_q       <= acc_d;
      sn_q        <= sn_d;
      wb_q        <= wb_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        key_len_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q     <= data_d;
    out_data_q <= out_data_d;
  end

  rc4_perm_ram u_perm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (perm_req),
    .rdata_o (perm_rdata)
  );

  rc4_key_ram u_key (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (s_axis_tdata[7:0]),
    .wdata_i (s_axis_tdata[15:8]),
    .raddr_i (kpos_q),
    .rdata_o (key_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_data_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (kind == rc4_pkg::KIND_DATA)) |=> (state_q == ST_D1))
    else $error("data transfer did not start keystream step");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_D3) && out_free) |=> (m_axis_tvalid && (state_q != ST_D3)))
    else $error("keystream result not registered");

  a_sched_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_KW) |=> ((state_q == ST_IDLE) && (i_q == '0) && (j_q == '0)))
    else $error("schedule did not finish with cleared indices");

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking testbench for rc4_stream_cipher
// Drives key, schedule, data and unused-kind transfers over the input
// stream, predicts every cipher and keystream byte in a scoreboard, and
// steps through several key lengths and handshake idling patterns.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam int         SCHED_CYCLES = 800;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         NUM_PHASES   = 9;

  typedef struct packed {
    logic [rc4_pkg::BYTE_W-1:0] stream_b;
    logic [rc4_pkg::BYTE_W-1:0] cipher_b;
  } cipher_res_t;

  class rc4_scoreboard;
    logic [rc4_pkg::BYTE_W-1:0] perm [rc4_pkg::TABLE_SIZE];
    logic [rc4_pkg::BYTE_W-1:0] keys [rc4_pkg::TABLE_SIZE];
    logic [rc4_pkg::BYTE_W-1:0] idx_i;
    logic [rc4_pkg::BYTE_W-1:0] idx_j;
    logic [rc4_pkg::LEN_W-1:0]  key_len;
    cipher_res_t                pending_bytes[$];
    int                         errors;
    int                         checked;

    function new();
      for (int n = 0; n < rc4_pkg::TABLE_SIZE; n++) begin
        perm[n] = n[rc4_pkg::BYTE_W-1:0];
        keys[n] = '0;
      end
      idx_i   = '0;
      idx_j   = '0;
      key_len = rc4_pkg::KEY_LEN_RESET;
      errors  = 0;
      checked = 0;
    endfunction

    function void swap_perm(logic [rc4_pkg::BYTE_W-1:0] a, logic [rc4_pkg::BYTE_W-1:0] b);
      logic [rc4_pkg::BYTE_W-1:0] tmp;
      tmp     = perm[a];
      perm[a] = perm[b];
      perm[b] = tmp;
    endfunction

    function void schedule_key();
      int                         len;
      int                         kpos;
      logic [rc4_pkg::BYTE_W-1:0] acc;
      len  = key_len;
      kpos = 0;
      acc  = '0;
      // zero and anything above the table size mean the full table
      if (len == 0 || len > rc4_pkg::TABLE_SIZE) len = rc4_pkg::TABLE_SIZE;
      for (int n = 0; n < rc4_pkg::TABLE_SIZE; n++) perm[n] = n[rc4_pkg::BYTE_W-1:0];
      for (int n = 0; n < rc4_pkg::TABLE_SIZE; n++) begin
        acc = acc + perm[n] + keys[kpos];
        swap_perm(n[rc4_pkg::BYTE_W-1:0], acc);
        kpos++;
        if (kpos >= len) kpos = 0;
      end
      idx_i = '0;
      idx_j = '0;
    endfunction

    function void advance_keystream(logic [rc4_pkg::BYTE_W-1:0] data_b);
      logic [rc4_pkg::BYTE_W-1:0] sum;
      cipher_res_t                res;
      idx_i = idx_i + 1'b1;
      idx_j = idx_j + perm[idx_i];
      swap_perm(idx_i, idx_j);
      sum          = perm[idx_i] + perm[idx_j];
      res.stream_b = perm[sum];
      res.cipher_b = data_b ^ perm[sum];
      pending_bytes.insert(pending_bytes.size(), res);
    endfunction

    function void note_transfer(logic [1:0] kind, logic [rc4_pkg::BYTE_W-1:0] kidx,
                                logic [rc4_pkg::BYTE_W-1:0] val);
      case (kind)
        rc4_pkg::KIND_KEY:   keys[kidx] = val;
        rc4_pkg::KIND_SCHED: schedule_key();
        rc4_pkg::KIND_DATA:  advance_keystream(val);
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_cipher_byte(logic [15:0] tdata);
      cipher_res_t got;
      cipher_res_t exp;
      got = tdata;
      if (pending_bytes.size() == 0) begin
        report($sformatf("unexpected result %h", tdata));
      end else begin
        exp = pending_bytes.pop_front();
        checked++;
        if (got.cipher_b !== exp.cipher_b)
          report($sformatf("out_byte %h, expected %h", got.cipher_b, exp.cipher_b));
        if (got.stream_b !== exp.stream_b)
          report($sformatf("stream_byte %h, expected %h", got.stream_b, exp.stream_b));
      end
    endtask

    function int pending();
      return pending_bytes.size();
    endfunction
  endclass

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      cfg_we_i      = 1'b0;
  logic [rc4_pkg::LEN_W-1:0] cfg_wdata_i   = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [15:0]               s_axis_tdata  = '0;  // key_index[7:0], byte_value[15:8]
  logic [1:0]                s_axis_tuser  = '0;  // kind[1:0]
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b1;
  logic [15:0]               m_axis_tdata;        // out_byte[7:0], stream_byte[15:8]

  rc4_scoreboard sb = new();

  int                        gap_pct   = 0;
  int                        stall_pct = 0;
  int                        hold_req  = 0;
  int                        hold_left = 0;
  logic [rc4_pkg::LEN_W-1:0] cur_len   = rc4_pkg::KEY_LEN_RESET;
  bit                        key_written [rc4_pkg::TABLE_SIZE];
  int                        n_key, n_sched, n_data, n_unused;

  rc4_stream_cipher i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready)
      sb.note_transfer(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8]);
    if (m_axis_tvalid && m_axis_tready)
      sb.check_cipher_byte(m_axis_tdata);
  end

  // receiver: long hold-off on request, otherwise random stalls
  always @(posedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic send_item(input logic [1:0] kind, input logic [7:0] kidx,
                           input logic [7:0] val);
    while ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {val, kidx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    case (kind)
      rc4_pkg::KIND_KEY: begin
        key_written[kidx] = 1'b1;
        n_key++;
      end
      rc4_pkg::KIND_SCHED: n_sched++;
      rc4_pkg::KIND_DATA:  n_data++;
      default:             n_unused++;
    endcase
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // a schedule never reads a key entry that was never loaded
  task automatic send_schedule();
    int len;
    len = cur_len;
    if (len == 0 || len > rc4_pkg::TABLE_SIZE) len = rc4_pkg::TABLE_SIZE;
    for (int k = 0; k < len; k++)
      if (!key_written[k]) send_item(rc4_pkg::KIND_KEY, k[7:0], 8'($urandom));
    send_item(rc4_pkg::KIND_SCHED, 8'($urandom), 8'($urandom));
  endtask

  task automatic write_key_length(input logic [rc4_pkg::LEN_W-1:0] len);
    drain_results();
    repeat (SCHED_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_len     = len;
    sb.key_len  = len;
  endtask

  task automatic run_random(input int count);
    int r;
    int done;
    done = 0;
    send_schedule();
    while (done < count) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        send_item(rc4_pkg::KIND_DATA, 8'($urandom), 8'($urandom));
      end else if (r < 84) begin
        send_item(rc4_pkg::KIND_KEY, 8'($urandom), 8'($urandom));
      end else if (r < 90) begin
        send_schedule();
      end else if (r < 94) begin
        send_item(KIND_UNUSED, 8'($urandom), 8'($urandom));
        done--;
      end else begin
        send_item(rc4_pkg::KIND_DATA, 8'($urandom),
                  ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00);
      end
      done++;
    end
  endtask

  task automatic run_directed();
    send_item(rc4_pkg::KIND_DATA, 8'h00, 8'h00);
    send_item(rc4_pkg::KIND_DATA, 8'hFF, 8'hFF);
    send_item(KIND_UNUSED, 8'hFF, 8'hFF);
    send_item(rc4_pkg::KIND_KEY, 8'd0, 8'h00);
    send_item(rc4_pkg::KIND_KEY, 8'd1, 8'hFF);
    for (int k = 2; k < 16; k++) send_item(rc4_pkg::KIND_KEY, k[7:0], 8'($urandom));
    send_item(rc4_pkg::KIND_KEY, rc4_pkg::LAST_INDEX, 8'hFF);
    send_schedule();
    send_item(rc4_pkg::KIND_DATA, 8'h00, 8'h00);
    send_item(rc4_pkg::KIND_DATA, 8'h00, 8'hFF);
    // new key byte must not disturb the running stream
    send_item(rc4_pkg::KIND_KEY, 8'd0, 8'h80);
    send_item(rc4_pkg::KIND_DATA, 8'h00, 8'h5A);
  endtask

  initial begin
    logic [rc4_pkg::LEN_W-1:0] phase_len [NUM_PHASES];
    int                        phase_gap [NUM_PHASES];
    int                        phase_stall [NUM_PHASES];
    phase_len   = '{rc4_pkg::KEY_LEN_RESET, 9'd1, 9'd256, 9'd0, 9'd0, 9'd511, 9'd2,
                    9'd255, 9'd0};
    phase_gap   = '{0, 79, 0, 10, 0, 79, 0, 10, 0};
    phase_stall = '{0, 0, 79, 10, 0, 0, 79, 10, 0};
    phase_len[3] = 9'($urandom_range(1, 256));
    phase_len[8] = 9'($urandom_range(1, 256));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 0) begin
        run_directed();
      end else begin
        write_key_length(phase_len[p]);
      end
      gap_pct   = phase_gap[p];
      stall_pct = phase_stall[p];
      if (p == 1) begin
        run_random(90);
        drain_results();
        run_random(95);
      end else if (p == 2) begin
        run_random(90);
        // hold the result side while data keeps coming
        hold_req = HOLD_CYCLES;
        for (int k = 0; k < 20; k++)
          send_item(rc4_pkg::KIND_DATA, 8'($urandom), 8'($urandom));
        run_random(75);
      end else begin
        run_random(p == 0 ? 160 : 185);
      end
    end

    drain_results();
    repeat (SCHED_CYCLES) @(posedge clk_i);
    $display("covered %0d key lengths incl. 0, 1, 256 and 511 under four idling patterns",
             NUM_PHASES);
    $display("%0d data bytes sent, %0d checked, %0d key bytes, %0d schedules, %0d unused",
             n_data, sb.checked, n_key, n_sched, n_unused);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
